// ===== sv/bfpr_pkg.sv =====
package bfpr_pkg;

    localparam logic [7:0] OpenMark  = 8'h7B;
    localparam logic [7:0] CloseMark = 8'h7D;
    localparam int         FrameLen  = 9;
    localparam int         SumLen    = 8;
    localparam int         CheckMod  = 100;
    localparam int         CountW    = $clog2(FrameLen + 1);
    localparam int         SumW      = $clog2(CheckMod);

    typedef logic [7:0]        byte_t;
    typedef logic [CountW-1:0] count_t;
    typedef logic [SumW-1:0]   sum_t;
    typedef byte_t [FrameLen-1:0] frame_t;

    typedef struct packed {
        logic fire;
        logic emit;
    } step_t;

endpackage

// ===== sv/bfpr_if.sv =====
interface bfpr_byte_if;
    logic               valid;
    logic               ready;
    bfpr_pkg::byte_t    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfpr_frame_if;
    logic               valid;
    logic               ready;
    bfpr_pkg::byte_t    dest_id;
    bfpr_pkg::byte_t    command;
    bfpr_pkg::byte_t    arg_one;
    bfpr_pkg::byte_t    arg_two;
    bfpr_pkg::byte_t    arg_three;
    bfpr_pkg::byte_t    arg_four;
    bfpr_pkg::byte_t    arg_five;
    bfpr_pkg::byte_t    arg_six;
    bfpr_pkg::byte_t    check_byte;

    modport source (
        output valid, input ready,
        output dest_id, output command, output arg_one, output arg_two,
        output arg_three, output arg_four, output arg_five, output arg_six,
        output check_byte
    );
    modport sink (
        input valid, output ready,
        input dest_id, input command, input arg_one, input arg_two,
        input arg_three, input arg_four, input arg_five, input arg_six,
        input check_byte
    );
endinterface

// ===== sv/bfpr_frame_capture.sv =====
module bfpr_frame_capture (
    input  logic                    clk,
    input  logic                    rst_n,
    bfpr_byte_if.sink               rx,
    input  logic                    sink_free,
    output bfpr_pkg::step_t         step,
    output bfpr_pkg::frame_t        frame_data
);

    localparam bfpr_pkg::count_t FullCount = bfpr_pkg::count_t'(bfpr_pkg::FrameLen);
    localparam bfpr_pkg::count_t SumCount  = bfpr_pkg::count_t'(bfpr_pkg::SumLen);
    localparam logic [7:0]       Mod8      = 8'(bfpr_pkg::CheckMod);
    localparam logic [7:0]       Mod8x2    = 8'(2 * bfpr_pkg::CheckMod);

    logic               in_valid_reg;
    bfpr_pkg::byte_t    in_byte_reg;
    bfpr_pkg::count_t   count_reg;
    bfpr_pkg::count_t   count_next;
    logic               open_reg;
    logic               open_next;
    bfpr_pkg::sum_t     sum_reg;
    bfpr_pkg::sum_t     sum_next;
    bfpr_pkg::frame_t   store_reg;

    logic               fire;
    logic               is_close;
    logic               is_open;
    bfpr_pkg::count_t   count_mid;
    logic               open_mid;
    logic               wr_en;
    logic [7:0]         byte_mod;
    bfpr_pkg::sum_t     sum_base;
    logic [7:0]         sum_raw;
    logic               check_ok;

    assign fire     = in_valid_reg && sink_free;
    assign rx.ready = !in_valid_reg || sink_free;
    assign is_close = (in_byte_reg == bfpr_pkg::CloseMark);
    assign is_open  = (in_byte_reg == bfpr_pkg::OpenMark);

    assign check_ok = ({1'b0, sum_reg} == store_reg[bfpr_pkg::SumLen]);

    always_comb
    begin
        count_mid = is_close ? '0 : count_reg;
        open_mid  = is_close ? 1'b0 : open_reg;
        wr_en     = open_mid && (count_mid < FullCount);

        count_next = count_mid;
        open_next  = open_mid;
        if (open_mid)
        begin
            if (wr_en)
                count_next = count_mid + 1'b1;
            else
                open_next = 1'b0;
        end
        if (is_open)
        begin
            open_next  = 1'b1;
            count_next = '0;
        end
    end

    // running sum mod 100 of bytes 0..7
    always_comb
    begin
        if (in_byte_reg >= Mod8x2)
            byte_mod = in_byte_reg - Mod8x2;
        else if (in_byte_reg >= Mod8)
            byte_mod = in_byte_reg - Mod8;
        else
            byte_mod = in_byte_reg;

        sum_base = (count_mid == '0) ? '0 : sum_reg;
        sum_raw  = {1'b0, sum_base} + byte_mod;
        if (sum_raw >= Mod8)
            sum_raw = sum_raw - Mod8;

        sum_next = sum_reg;
        if (wr_en && (count_mid < SumCount))
            sum_next = bfpr_pkg::sum_t'(sum_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            open_reg     <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            if (rx.ready)
                in_valid_reg <= rx.valid;
            if (fire)
            begin
                count_reg <= count_next;
                open_reg  <= open_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
        for (int i = 0; i < bfpr_pkg::FrameLen; i++)
        begin
            if (fire && wr_en && (count_mid == bfpr_pkg::count_t'(i)))
                store_reg[i] <= in_byte_reg;
        end
    end

    assign step.fire  = fire;
    assign step.emit  = is_close && (count_reg == FullCount) && check_ok;
    assign frame_data = store_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCount)
        else $error("byte count beyond frame length");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg < bfpr_pkg::sum_t'(bfpr_pkg::CheckMod))
        else $error("running sum not reduced");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_close) |=> (count_reg == '0))
        else $error("close byte did not clear count");

endmodule

// ===== sv/bfpr_result_reg.sv =====
module bfpr_result_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bfpr_pkg::step_t         step,
    input  bfpr_pkg::frame_t        frame_data,
    output logic                    sink_free,
    bfpr_frame_if.source            frame
);

    logic               out_valid_reg;
    bfpr_pkg::frame_t   out_data_reg;

    assign sink_free = !out_valid_reg || frame.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (sink_free)
            out_valid_reg <= step.fire && step.emit;
    end

    always_ff @(posedge clk)
    begin
        if (step.fire && step.emit)
            out_data_reg <= frame_data;
    end

    assign frame.valid      = out_valid_reg;
    assign frame.dest_id    = out_data_reg[0];
    assign frame.command    = out_data_reg[1];
    assign frame.arg_one    = out_data_reg[2];
    assign frame.arg_two    = out_data_reg[3];
    assign frame.arg_three  = out_data_reg[4];
    assign frame.arg_four   = out_data_reg[5];
    assign frame.arg_five   = out_data_reg[6];
    assign frame.arg_six    = out_data_reg[7];
    assign frame.check_byte = out_data_reg[8];

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && step.emit) |=> out_valid_reg)
        else $error("emitted frame not presented");

    a_no_fire_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        step.fire |-> sink_free)
        else $error("step advanced into a full result register");

endmodule

// ===== sv/brace_framed_packet_receiver.sv =====
// A result passes through the input register, then the result register, before it is
//   valid at the output; a full result register that is not taken can hold it in between.
// Throughput: one received byte per cycle; the input side stalls only while a
//   finished frame waits at the output and is not taken.
// Reset (rst_n, async, active low) clears the valid flags, byte count, open flag
//   and running sum; the frame store is not cleared.
module brace_framed_packet_receiver (
    input  logic            clk,
    input  logic            rst_n,
    bfpr_byte_if.sink       rx,
    bfpr_frame_if.source    frame
);

    bfpr_pkg::step_t    step;
    bfpr_pkg::frame_t   frame_data;
    logic               sink_free;

    bfpr_frame_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .sink_free  (sink_free),
        .step       (step),
        .frame_data (frame_data)
    );

    bfpr_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .frame_data (frame_data),
        .sink_free  (sink_free),
        .frame      (frame)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int IdlePct  = 25;
    localparam int QuietLo  = 250;
    localparam int QuietHi  = 550;
    localparam int HoldAt   = 900;
    localparam int HoldLen  = 300;
    localparam int PauseAt  = 650;
    localparam int NumBytes = 1050;
    localparam int MaxShown = 10;

    logic clk;
    logic rst_n;

    bfpr_byte_if  rx_ch ();
    bfpr_frame_if frame_ch ();

    brace_framed_packet_receiver u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch)
    );

    bfpr_pkg::byte_t  pending_bytes[$];
    bfpr_pkg::frame_t expected_frames[$];

    // receiver state mirror
    bfpr_pkg::byte_t  frame_buf[bfpr_pkg::FrameLen];
    bfpr_pkg::count_t rx_count = '0;
    logic             in_frame = 1'b0;

    int     cyc;
    int     hold_left;
    int     issued;
    int     accepted;
    int     total_bytes;
    int     errors = 0;
    logic   quiet;
    bfpr_pkg::frame_t got;
    bfpr_pkg::frame_t want;

    string  field_name[bfpr_pkg::FrameLen] = '{"dest_id", "command", "arg_one", "arg_two",
                                               "arg_three", "arg_four", "arg_five",
                                               "arg_six", "check_byte"};

    assign quiet = (cyc >= QuietLo) && (cyc < QuietHi);

    function automatic void predict_byte(input bfpr_pkg::byte_t b);
        int               sum;
        bfpr_pkg::frame_t f;
        if (b == bfpr_pkg::CloseMark)
        begin
            if (rx_count == bfpr_pkg::count_t'(bfpr_pkg::FrameLen))
            begin
                sum = 0;
                for (int k = 0; k < bfpr_pkg::SumLen; k++)
                    sum += frame_buf[k];
                if ((sum % bfpr_pkg::CheckMod) == int'(frame_buf[bfpr_pkg::SumLen]))
                begin
                    for (int k = 0; k < bfpr_pkg::FrameLen; k++)
                        f[k] = frame_buf[k];
                    expected_frames.push_back(f);
                end
            end
            rx_count = '0;
            in_frame = 1'b0;
        end
        if (in_frame)
        begin
            if (rx_count >= bfpr_pkg::count_t'(bfpr_pkg::FrameLen))
                in_frame = 1'b0;
            else
            begin
                frame_buf[rx_count] = b;
                rx_count = rx_count + 1'b1;
            end
        end
        if (b == bfpr_pkg::OpenMark)
        begin
            in_frame = 1'b1;
            rx_count = '0;
        end
    endfunction

    function automatic bfpr_pkg::byte_t data_byte();
        bfpr_pkg::byte_t b;
        do
            b = bfpr_pkg::byte_t'($urandom_range(0, 255));
        while (b == bfpr_pkg::OpenMark || b == bfpr_pkg::CloseMark);
        return b;
    endfunction

    task automatic push_frame(input bit good_sum, input int n_data, input int n_extra);
        bfpr_pkg::byte_t b;
        int              sum;
        sum = 0;
        pending_bytes.push_back(bfpr_pkg::OpenMark);
        for (int k = 0; k < n_data; k++)
        begin
            b = data_byte();
            sum += b;
            pending_bytes.push_back(b);
        end
        if (good_sum)
            pending_bytes.push_back(bfpr_pkg::byte_t'(sum % bfpr_pkg::CheckMod));
        else
            pending_bytes.push_back(data_byte());
        repeat (n_extra)
            pending_bytes.push_back(data_byte());
        pending_bytes.push_back(bfpr_pkg::CloseMark);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cyc <= 0;
        else
            cyc <= cyc + 1;
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (cyc == HoldAt)
            hold_left <= HoldLen;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
            issued        <= 0;
            accepted      <= 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                predict_byte(rx_ch.rx_byte);
                accepted <= accepted + 1;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (pending_bytes.size() != 0
                    && (quiet || $urandom_range(0, 99) >= IdlePct)
                    && !(issued == PauseAt && expected_frames.size() != 0))
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= pending_bytes.pop_front();
                    issued        <= issued + 1;
                end
                else
                    rx_ch.valid <= 1'b0;
            end
        end
    end

    // frame monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_ch.ready <= 1'b0;
        else
        begin
            frame_ch.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= IdlePct);
            if (frame_ch.valid && frame_ch.ready)
            begin
                got[0] = frame_ch.dest_id;
                got[1] = frame_ch.command;
                got[2] = frame_ch.arg_one;
                got[3] = frame_ch.arg_two;
                got[4] = frame_ch.arg_three;
                got[5] = frame_ch.arg_four;
                got[6] = frame_ch.arg_five;
                got[7] = frame_ch.arg_six;
                got[8] = frame_ch.check_byte;
                if (expected_frames.size() == 0)
                begin
                    if (errors < MaxShown)
                        $display("%0t: unexpected frame %h", $realtime, got);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    for (int k = 0; k < bfpr_pkg::FrameLen; k++)
                    begin
                        if (got[k] !== want[k])
                        begin
                            if (errors < MaxShown)
                                $display("%0t: %s expected %h got %h", $realtime,
                                         field_name[k], want[k], got[k]);
                            errors = errors + 1;
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        int sel;
        rst_n = 1'b0;

        pending_bytes.push_back(bfpr_pkg::OpenMark);
        repeat (bfpr_pkg::SumLen)
            pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'd40);
        pending_bytes.push_back(bfpr_pkg::CloseMark);

        // overlong frame, then a close with no frame open
        pending_bytes.push_back(bfpr_pkg::OpenMark);
        for (int k = 1; k <= bfpr_pkg::SumLen; k++)
            pending_bytes.push_back(bfpr_pkg::byte_t'(k));
        pending_bytes.push_back(8'd36);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(bfpr_pkg::CloseMark);

        // open mark inside a frame, check byte out of range
        pending_bytes.push_back(bfpr_pkg::OpenMark);
        pending_bytes.push_back(bfpr_pkg::OpenMark);
        repeat (bfpr_pkg::SumLen)
            pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'd100);
        pending_bytes.push_back(bfpr_pkg::CloseMark);

        while (pending_bytes.size() < NumBytes)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                push_frame(1'b1, bfpr_pkg::SumLen, 0);
            else if (sel < 78)
                push_frame(1'b0, bfpr_pkg::SumLen, 0);
            else if (sel < 84)
                push_frame(1'b1, bfpr_pkg::SumLen, $urandom_range(1, 3));
            else if (sel < 90)
                push_frame(1'b1, $urandom_range(0, bfpr_pkg::SumLen - 1), 0);
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    case ($urandom_range(0, 5))
                        0:       pending_bytes.push_back(bfpr_pkg::OpenMark);
                        1:       pending_bytes.push_back(bfpr_pkg::CloseMark);
                        default: pending_bytes.push_back(
                                     bfpr_pkg::byte_t'($urandom_range(0, 255)));
                    endcase
                end
            end
        end
        total_bytes = pending_bytes.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted != total_bytes)
            @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
